// ===== hw/rtl/scc_pkg.sv =====
package scc_pkg;

	// Low bits of the byte offset that the parser needs: enough for the
	// largest padding boundary (0x8000 << 3).
	localparam int OFFSET_W = 18;

	localparam logic [31:0] HDR_MAGIC   = 32'h0FF512ED;
	localparam logic [15:0] HDR_VERSION = 16'h0100;
	localparam logic [4:0]  WIN_BASE    = 5'd15;
	localparam logic [5:0]  NARROW_BITS = 6'd20;
	localparam logic [5:0]  WIDE_BITS   = 6'd32;

	// Frame size is 1 << FRAME_LOG bytes (32768)
	localparam int FRAME_LOG = 15;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_TABLE,
		PH_RAW,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_PAYLOAD,
		PH_PAD,
		PH_HALT
	} phase_t;

	// Result kinds
	localparam logic [2:0] KIND_NONE   = 3'd0;
	localparam logic [2:0] KIND_ENTRY  = 3'd1;
	localparam logic [2:0] KIND_CHUNK  = 3'd2;
	localparam logic [2:0] KIND_RAW    = 3'd3;
	localparam logic [2:0] KIND_HEADER = 3'd4;

	// Status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SHORT_HDR = 3'd1;
	localparam logic [2:0] ST_BAD_HDR   = 3'd2;
	localparam logic [2:0] ST_TABLE_END = 3'd3;
	localparam logic [2:0] ST_BAD_PAD   = 3'd4;
	localparam logic [2:0] ST_CHUNK_END = 3'd5;
	localparam logic [2:0] ST_COUNT     = 3'd6;
	localparam logic [2:0] ST_TRAIL     = 3'd7;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [31:0] value;
		logic [15:0] entry_index;
		logic        chunk_first;
		logic        chunk_last;
		logic [4:0]  window_log;
		logic [4:0]  pad_boundary_log;
		logic        wide_entries;
		logic        done_res;
		logic [2:0]  status;
	} res_t;

endpackage

// ===== hw/rtl/scc_parser.sv =====
// Container parser: all per-file state, one byte consumed per accepted beat.
module scc_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output scc_pkg::res_t       res
);

	logic [scc_pkg::OFFSET_W-1:0] offset_q, offset_nxt, off_inc, pad_mask;
	scc_pkg::phase_t              phase_q, phase_nxt;
	logic [23:0]                  flags_q, flags_nxt, flags_in;
	logic                         hdr_bad_q, hdr_bad_nxt;
	logic [31:0]                  acc_q, acc_nxt;
	logic [5:0]                   bit_cnt_q, bit_cnt_nxt;
	logic [15:0]                  entries_left_q, entries_left_nxt;
	logic [17:0]                  table_bytes_q, table_bytes_nxt;
	logic [7:0]                   len_hi_q, len_hi_nxt;
	logic [15:0]                  chunk_left_q, chunk_left_nxt;
	logic [33:0]                  frames_exp_q, frames_exp_nxt;
	logic [33:0]                  chunks_seen_q, chunks_seen_nxt;
	logic [2:0]                   err_q, err_nxt;
	logic                         pay_first_q, pay_first_nxt;

	logic [3:0]  hdr_pos;
	logic [7:0]  hdr_expect;
	logic        hdr_check_byte;
	logic [15:0] seg_cur, seg_new;
	logic        wide_cur, wide_new;
	logic [18:0] five_s;
	logic [18:0] narrow_words;
	logic [15:0] tbl_word_cnt;
	logic [17:0] table_bytes_init;
	logic [5:0]  bps, cnt_add, cnt_rem;
	logic [31:0] acc_sh, ent_raw, ent_val;
	logic        entry_done;
	logic [33:0] frames_add;
	logic        at_bnd, nxt_bnd;
	logic [15:0] chunk_len, chunk_dec;
	logic [2:0]  end_err;
	logic        need_count;
	logic        decoded;

	// Header byte checks
	assign hdr_pos = offset_q[3:0];
	always_comb begin
		hdr_expect     = 8'h00;
		hdr_check_byte = 1'b0;
		case (hdr_pos)
			4'd0: begin hdr_expect = scc_pkg::HDR_MAGIC[31:24]; hdr_check_byte = 1'b1; end
			4'd1: begin hdr_expect = scc_pkg::HDR_MAGIC[23:16]; hdr_check_byte = 1'b1; end
			4'd2: begin hdr_expect = scc_pkg::HDR_MAGIC[15:8];  hdr_check_byte = 1'b1; end
			4'd3: begin hdr_expect = scc_pkg::HDR_MAGIC[7:0];   hdr_check_byte = 1'b1; end
			4'd4: begin hdr_expect = scc_pkg::HDR_VERSION[15:8]; hdr_check_byte = 1'b1; end
			4'd5: begin hdr_expect = scc_pkg::HDR_VERSION[7:0];  hdr_check_byte = 1'b1; end
			default: begin hdr_expect = 8'h00; hdr_check_byte = 1'b0; end
		endcase
	end

	// Flag decodes, current and with this byte shifted in
	assign flags_in = {flags_q[15:0], data_byte};
	assign seg_cur  = flags_q[21:6];
	assign wide_cur = |flags_q[23:22];
	assign seg_new  = flags_in[21:6];
	assign wide_new = |flags_in[23:22];

	// Table length in bytes, padded to whole 32-bit words
	assign five_s           = {1'b0, seg_new, 2'b00} + {3'b000, seg_new};
	assign narrow_words     = (five_s + 19'd7) >> 3;
	assign tbl_word_cnt     = wide_new ? seg_new : narrow_words[15:0];
	assign table_bytes_init = {tbl_word_cnt, 2'b00};

	// Size table unpacking
	assign bps        = wide_cur ? scc_pkg::WIDE_BITS : scc_pkg::NARROW_BITS;
	assign acc_sh     = {acc_q[23:0], data_byte};
	assign cnt_add    = bit_cnt_q + 6'd8;
	assign entry_done = (cnt_add >= bps);
	assign cnt_rem    = cnt_add - bps;
	assign ent_raw    = acc_sh >> cnt_rem;
	assign ent_val    = wide_cur ? ent_raw : {12'h000, ent_raw[19:0]};
	assign frames_add = {{(34 - 32 + scc_pkg::FRAME_LOG){1'b0}}, ent_val[31:scc_pkg::FRAME_LOG]}
		+ {33'd0, |ent_val[scc_pkg::FRAME_LOG-1:0]};

	// Padding boundary tests
	assign off_inc  = offset_q + {{(scc_pkg::OFFSET_W-1){1'b0}}, 1'b1};
	assign pad_mask = {flags_q[5:4] == 2'd3, flags_q[5:4] >= 2'd2, flags_q[5:4] != 2'd0,
		15'h7FFF};
	assign at_bnd   = (offset_q & pad_mask) == '0;
	assign nxt_bnd  = (off_inc & pad_mask) == '0;

	assign chunk_len = {len_hi_q, data_byte};
	assign chunk_dec = chunk_left_q - 16'd1;

	// Next state
	always_comb begin
		offset_nxt       = off_inc;
		phase_nxt        = phase_q;
		flags_nxt        = flags_q;
		hdr_bad_nxt      = hdr_bad_q;
		acc_nxt          = acc_q;
		bit_cnt_nxt      = bit_cnt_q;
		entries_left_nxt = entries_left_q;
		table_bytes_nxt  = table_bytes_q;
		len_hi_nxt       = len_hi_q;
		chunk_left_nxt   = chunk_left_q;
		frames_exp_nxt   = frames_exp_q;
		chunks_seen_nxt  = chunks_seen_q;
		err_nxt          = err_q;
		pay_first_nxt    = pay_first_q;
		end_err          = scc_pkg::ST_OK;
		need_count       = 1'b0;

		unique case (phase_q)
			scc_pkg::PH_HEADER: begin
				if (hdr_check_byte && data_byte != hdr_expect)
					hdr_bad_nxt = 1'b1;
				if (hdr_pos >= 4'd12)
					flags_nxt = flags_in;
				if (hdr_pos == 4'd15) begin
					if (hdr_bad_q) begin
						err_nxt   = scc_pkg::ST_BAD_HDR;
						phase_nxt = scc_pkg::PH_HALT;
					end else if (seg_new == 16'd0) begin
						phase_nxt = scc_pkg::PH_RAW;
					end else begin
						phase_nxt        = scc_pkg::PH_TABLE;
						entries_left_nxt = seg_new;
						table_bytes_nxt  = table_bytes_init;
						acc_nxt          = 32'd0;
						bit_cnt_nxt      = 6'd0;
						if (last_byte)
							end_err = scc_pkg::ST_TABLE_END;
					end
				end else if (last_byte) begin
					end_err = scc_pkg::ST_SHORT_HDR;
				end
			end
			scc_pkg::PH_TABLE: begin
				if (entries_left_q != 16'd0) begin
					if (entry_done) begin
						bit_cnt_nxt      = cnt_rem;
						acc_nxt          = acc_sh & ~(32'hFFFF_FFFF << cnt_rem);
						frames_exp_nxt   = frames_exp_q + frames_add;
						entries_left_nxt = entries_left_q - 16'd1;
					end else begin
						bit_cnt_nxt = cnt_add;
						acc_nxt     = acc_sh;
					end
				end
				table_bytes_nxt = table_bytes_q - 18'd1;
				if (table_bytes_nxt == 18'd0)
					phase_nxt = scc_pkg::PH_LEN_HI;
				if (last_byte) begin
					if (table_bytes_nxt != 18'd0)
						end_err = scc_pkg::ST_TABLE_END;
					else
						need_count = 1'b1;
				end
			end
			scc_pkg::PH_RAW: begin
				phase_nxt = scc_pkg::PH_RAW;
			end
			scc_pkg::PH_LEN_HI: begin
				len_hi_nxt = data_byte;
				phase_nxt  = scc_pkg::PH_LEN_LO;
				if (last_byte) begin
					if (data_byte != 8'h00)
						end_err = scc_pkg::ST_TRAIL;
					else
						need_count = 1'b1;
				end
			end
			scc_pkg::PH_LEN_LO: begin
				if (chunk_len != 16'd0) begin
					chunks_seen_nxt = chunks_seen_q + 34'd1;
					chunk_left_nxt  = chunk_len;
					pay_first_nxt   = 1'b1;
					phase_nxt       = scc_pkg::PH_PAYLOAD;
					if (last_byte)
						end_err = scc_pkg::ST_CHUNK_END;
				end else begin
					// zero word: this low byte on a boundary doubles as the next high byte
					if (at_bnd) begin
						len_hi_nxt = 8'h00;
						phase_nxt  = scc_pkg::PH_LEN_LO;
					end else if (nxt_bnd) begin
						phase_nxt = scc_pkg::PH_LEN_HI;
					end else begin
						phase_nxt = scc_pkg::PH_PAD;
					end
					if (last_byte)
						need_count = 1'b1;
				end
			end
			scc_pkg::PH_PAYLOAD: begin
				pay_first_nxt  = 1'b0;
				chunk_left_nxt = chunk_dec;
				if (chunk_dec == 16'd0)
					phase_nxt = scc_pkg::PH_LEN_HI;
				if (last_byte) begin
					if (chunk_dec != 16'd0)
						end_err = scc_pkg::ST_CHUNK_END;
					else
						need_count = 1'b1;
				end
			end
			scc_pkg::PH_PAD: begin
				if (data_byte != 8'h00) begin
					err_nxt   = scc_pkg::ST_BAD_PAD;
					phase_nxt = scc_pkg::PH_HALT;
				end else begin
					if (nxt_bnd)
						phase_nxt = scc_pkg::PH_LEN_HI;
					if (last_byte)
						need_count = 1'b1;
				end
			end
			scc_pkg::PH_HALT: begin
				phase_nxt = scc_pkg::PH_HALT;
			end
			default: begin
				phase_nxt = scc_pkg::PH_HALT;
			end
		endcase

		// End-of-file verdict, first error wins
		if (last_byte && err_nxt == scc_pkg::ST_OK) begin
			if (end_err == scc_pkg::ST_OK && need_count && chunks_seen_nxt != frames_exp_nxt)
				err_nxt = scc_pkg::ST_COUNT;
			else
				err_nxt = end_err;
		end
	end

	// Result fields
	assign decoded = (phase_nxt != scc_pkg::PH_HEADER) && !hdr_bad_nxt;

	always_comb begin
		res                  = '0;
		res.result_kind      = scc_pkg::KIND_NONE;
		res.window_log       = decoded ? ({1'b0, flags_nxt[3:0]} + scc_pkg::WIN_BASE) : 5'd0;
		res.pad_boundary_log = decoded ? ({3'b000, flags_nxt[5:4]} + scc_pkg::WIN_BASE) : 5'd0;
		res.wide_entries     = decoded && (|flags_nxt[23:22]);
		res.done_res         = last_byte;
		res.status           = err_nxt;
		unique case (phase_q)
			scc_pkg::PH_HEADER: begin
				if (hdr_pos == 4'd15 && !hdr_bad_q) begin
					res.result_kind = scc_pkg::KIND_HEADER;
					res.value       = {16'h0000, seg_new};
				end
			end
			scc_pkg::PH_TABLE: begin
				if (entries_left_q != 16'd0 && entry_done) begin
					res.result_kind = scc_pkg::KIND_ENTRY;
					res.value       = ent_val;
					res.entry_index = seg_cur - entries_left_q;
				end
			end
			scc_pkg::PH_RAW: begin
				res.result_kind = scc_pkg::KIND_RAW;
				res.value       = {24'h000000, data_byte};
			end
			scc_pkg::PH_PAYLOAD: begin
				res.result_kind = scc_pkg::KIND_CHUNK;
				res.value       = {24'h000000, data_byte};
				res.chunk_first = pay_first_q;
				res.chunk_last  = (chunk_dec == 16'd0);
			end
			default: begin
				res.result_kind = scc_pkg::KIND_NONE;
			end
		endcase
	end

	// State registers; the last byte of a file returns everything to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q       <= '0;
			phase_q        <= scc_pkg::PH_HEADER;
			flags_q        <= '0;
			hdr_bad_q      <= 1'b0;
			acc_q          <= '0;
			bit_cnt_q      <= '0;
			entries_left_q <= '0;
			table_bytes_q  <= '0;
			len_hi_q       <= '0;
			chunk_left_q   <= '0;
			frames_exp_q   <= '0;
			chunks_seen_q  <= '0;
			err_q          <= scc_pkg::ST_OK;
			pay_first_q    <= 1'b0;
		end else if (take) begin
			if (last_byte) begin
				offset_q       <= '0;
				phase_q        <= scc_pkg::PH_HEADER;
				flags_q        <= '0;
				hdr_bad_q      <= 1'b0;
				acc_q          <= '0;
				bit_cnt_q      <= '0;
				entries_left_q <= '0;
				table_bytes_q  <= '0;
				len_hi_q       <= '0;
				chunk_left_q   <= '0;
				frames_exp_q   <= '0;
				chunks_seen_q  <= '0;
				err_q          <= scc_pkg::ST_OK;
				pay_first_q    <= 1'b0;
			end else begin
				offset_q       <= offset_nxt;
				phase_q        <= phase_nxt;
				flags_q        <= flags_nxt;
				hdr_bad_q      <= hdr_bad_nxt;
				acc_q          <= acc_nxt;
				bit_cnt_q      <= bit_cnt_nxt;
				entries_left_q <= entries_left_nxt;
				table_bytes_q  <= table_bytes_nxt;
				len_hi_q       <= len_hi_nxt;
				chunk_left_q   <= chunk_left_nxt;
				frames_exp_q   <= frames_exp_nxt;
				chunks_seen_q  <= chunks_seen_nxt;
				err_q          <= err_nxt;
				pay_first_q    <= pay_first_nxt;
			end
		end
	end

endmodule

// ===== hw/rtl/scc_outbuf.sv =====
// Result register plus one skid entry, so input ready does not follow output ready.
module scc_outbuf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  scc_pkg::res_t in_res,
	output logic          out_valid,
	input  logic          out_ready,
	output scc_pkg::res_t out_res
);

	logic          out_valid_q, skid_valid_q;
	scc_pkg::res_t out_res_q, skid_res_q;
	logic          push, pop;

	assign in_ready  = !skid_valid_q;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid_q && out_ready;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			if (skid_valid_q)
				out_res_q <= skid_res_q;
			else if (push)
				out_res_q <= in_res;
		end else if (push) begin
			skid_res_q <= in_res;
		end
	end

endmodule

// ===== hw/rtl/segmented_chunk_container_deframer.sv =====
// Each accepted input beat yields exactly one result beat via the output register.
// Throughput: one byte per clock while in_ready is high.
// The two-entry output buffer keeps input ready high while one result waits.
// Reset (arst_n low, asynchronous) returns the parser to the header phase with
// all counters and the error latch cleared; the last byte of a file does the same.
module segmented_chunk_container_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  result_kind,
	output logic [31:0] value,
	output logic [15:0] entry_index,
	output logic        chunk_first,
	output logic        chunk_last,
	output logic [4:0]  window_log,
	output logic [4:0]  pad_boundary_log,
	output logic        wide_entries,
	output logic        done_res,
	output logic [2:0]  status
);

	scc_pkg::res_t parse_res, out_res;
	logic          take;

	assign take = in_valid && in_ready;

	scc_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.res       (parse_res)
	);

	scc_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_res    (parse_res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	// Unpack result beat onto ports
	assign result_kind      = out_res.result_kind;
	assign value            = out_res.value;
	assign entry_index      = out_res.entry_index;
	assign chunk_first      = out_res.chunk_first;
	assign chunk_last       = out_res.chunk_last;
	assign window_log       = out_res.window_log;
	assign pad_boundary_log = out_res.pad_boundary_log;
	assign wide_entries     = out_res.wide_entries;
	assign done_res         = out_res.done_res;
	assign status           = out_res.status;

endmodule
